// ===== rtl/core/rbfi_pkg.sv =====
// Package for the rigid body force integrator: sequencer states and helpers.
package rbfi_pkg;

  localparam int unsigned NumProd = 6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEVER,
    S_ZERO,
    S_AMUL,
    S_ASTORE,
    S_SUMS,
    S_RP0,
    S_RP1,
    S_RCMB,
    S_RDIV,
    S_RACC,
    S_TQ1,
    S_TQ2,
    S_TMUL,
    S_TADD,
    S_WRAP,
    S_DONE
  } rbfi_state_e;

  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic CFG_INV_MASS  = 1'b0;
  localparam logic CFG_MAX_ANGLE = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/rbfi_if.sv =====
// Request and result channel interfaces of the rigid body force integrator.
interface rbfi_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] loc_x;
  logic signed [31:0] loc_y;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic        [16:0] dt;
  modport source (output valid, op, loc_x, loc_y, force_x, force_y, dt, input ready);
  modport sink (input valid, op, loc_x, loc_y, force_x, force_y, dt, output ready);
endinterface

interface rbfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] angle;
  logic signed [31:0] ang_vel;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, angle, ang_vel, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, angle, ang_vel, output ready);
endinterface

// ===== rtl/core/rigid_body_force_integrator_unit.sv =====
// 2D rigid body integrator: apply-force and tick requests over one shared multiplier.
//
// in_i carries requests (op 0 apply force at a location, op 1 time step tick);
// out_o returns the body state after each request, one result per request.
// cfg_we_i/cfg_idx_i/cfg_data_i write inv_mass (index 0) and max_angle (index 1);
// the user must write them only while the block is idle; the block does not enforce it.
// One 33x33 signed multiplier is shared by every product under a sequencer;
// the radial force uses a restoring divider producing one quotient bit a cycle.
// Apply force with a nonzero lever runs the six lever products, then the two radial
// terms (two partial products, then 64 divide steps each unless the quotient overflows),
// then the torque and bookkeeping. A zero lever skips the products.
// A tick runs six multiply/accumulate pairs, then the angle wrap and the output.
// One request at a time: in_i.ready is high only when idle and no result waits.
// A stalled receiver holds the result register and blocks the next request.
// Reset clears the body state and accumulators and loads inv_mass = 1.0 and
// max_angle = 2 pi.
module rigid_body_force_integrator_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  rbfi_in_if.sink     in_i,
  rbfi_out_if.source  out_o
);
  import rbfi_pkg::*;

  localparam logic [63:0] InvMassRst  = 64'(64'd1 << FRAC_BITS);
  localparam logic [63:0] MaxAngleRst = 64'((64'd411775 << 8) >> (24 - FRAC_BITS));

  rbfi_state_e state_q, state_d;

  logic [30:0] inv_mass_q, max_angle_q;
  logic signed [31:0] px_q, py_q, vx_q, vy_q, ang_q, w_q, afx_q, afy_q, atq_q;

  logic signed [31:0] lx_q, ly_q, fx_q, fy_q;
  logic        [16:0] dt_q;
  logic signed [31:0] rx_q, ry_q;
  logic [2:0]         k_q;
  logic               ax_q;
  logic [5:0]         bit_q;
  logic signed [63:0] p_q [NumProd];
  logic [63:0]        r2_q, dmag_q, nl_q, rem_q, lo_q;
  logic               dneg_q, ovf_q;
  logic signed [64:0] cross_q;
  logic signed [65:0] prod_q;

  logic               ovalid_q;
  logic signed [31:0] o_px_q, o_py_q, o_vx_q, o_vy_q, o_ang_q, o_w_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] c_sel;
  logic [31:0]        cabs;
  logic               cneg;

  assign c_sel = ax_q ? ry_q : rx_q;
  assign cneg  = c_sel[31];
  assign cabs  = cneg ? (~c_sel + 32'd1) : c_sel;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_AMUL: begin
        case (k_q)
          3'd0: begin mul_a = 33'(rx_q); mul_b = 33'(rx_q); end
          3'd1: begin mul_a = 33'(ry_q); mul_b = 33'(ry_q); end
          3'd2: begin mul_a = 33'(rx_q); mul_b = 33'(fx_q); end
          3'd3: begin mul_a = 33'(ry_q); mul_b = 33'(fy_q); end
          3'd4: begin mul_a = 33'(rx_q); mul_b = 33'(fy_q); end
          default: begin mul_a = 33'(ry_q); mul_b = 33'(fx_q); end
        endcase
      end
      S_RP0: begin
        mul_a = {1'b0, dmag_q[31:0]};
        mul_b = {1'b0, cabs};
      end
      S_RP1: begin
        mul_a = {1'b0, dmag_q[63:32]};
        mul_b = {1'b0, cabs};
      end
      S_TMUL: begin
        case (k_q)
          3'd0: begin mul_a = 33'(afx_q); mul_b = {2'b0, inv_mass_q}; end
          3'd1: begin mul_a = 33'(afy_q); mul_b = {2'b0, inv_mass_q}; end
          3'd2: begin mul_a = 33'(vx_q); mul_b = {16'b0, dt_q}; end
          3'd3: begin mul_a = 33'(vy_q); mul_b = {16'b0, dt_q}; end
          3'd4: begin mul_a = 33'(atq_q); mul_b = {2'b0, inv_mass_q}; end
          default: begin mul_a = 33'(w_q); mul_b = {16'b0, dt_q}; end
        endcase
      end
      default: ;
    endcase
  end

  // lever
  logic signed [32:0] dx, dy;
  logic signed [31:0] rx_n, ry_n;
  assign dx   = 33'(lx_q) - 33'(px_q);
  assign dy   = 33'(ly_q) - 33'(py_q);
  assign rx_n = sat32(66'(dx));
  assign ry_n = sat32(66'(dy));

  // sums
  logic signed [65:0] dot;
  assign dot = 66'(p_q[2]) + 66'(p_q[3]);

  // divider step
  logic [64:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {rem_q, nl_q[63]};
  assign dv_ge = dv_t >= {1'b0, r2_q};

  // radial combine
  logic [95:0] num;
  assign num = {32'b0, lo_q} + {prod_q[63:0], 32'b0};

  // radial to saturated value
  logic signed [31:0] rad_v;
  always_comb begin
    if (dneg_q ^ cneg) begin
      rad_v = (ovf_q || nl_q >= 64'h80000000) ? 32'sh80000000 : -nl_q[31:0];
    end else begin
      rad_v = (ovf_q || nl_q > 64'h7fffffff) ? 32'sh7fffffff : nl_q[31:0];
    end
  end

  // torque
  logic [63:0]        cmag;
  logic signed [65:0] tq;
  assign cmag = cross_q[64] ? 64'(-cross_q) : cross_q[63:0];
  assign tq   = cross_q[64] ? -66'(cmag >> FRAC_BITS) : 66'(cmag >> FRAC_BITS);

  // tick product scaled, truncated toward zero
  logic signed [65:0] tsh, tsum;
  logic signed [31:0] tgt;
  always_comb begin
    tsh = prod_q >>> FRAC_BITS;
    if (prod_q[65] && (prod_q[FRAC_BITS-1:0] != '0)) begin
      tsh = tsh + 66'sd1;
    end
    case (k_q)
      3'd0: tgt = vx_q;
      3'd1: tgt = vy_q;
      3'd2: tgt = px_q;
      3'd3: tgt = py_q;
      3'd4: tgt = w_q;
      default: tgt = ang_q;
    endcase
    tsum = tsh + 66'(tgt);
  end

  logic accept;
  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE) && !ovalid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = (in_i.op == OP_TICK) ? S_TMUL : S_LEVER;
      S_LEVER:  state_d = (rx_n == '0 && ry_n == '0) ? S_ZERO : S_AMUL;
      S_ZERO:   state_d = S_DONE;
      S_AMUL:   state_d = S_ASTORE;
      S_ASTORE: state_d = (k_q == 3'(NumProd - 1)) ? S_SUMS : S_AMUL;
      S_SUMS:   state_d = S_RP0;
      S_RP0:    state_d = S_RP1;
      S_RP1:    state_d = S_RCMB;
      S_RCMB:   state_d = (num[95:64] >= r2_q) ? S_RACC : S_RDIV;
      S_RDIV:   if (bit_q == '1) state_d = S_RACC;
      S_RACC:   state_d = ax_q ? S_TQ1 : S_RP0;
      S_TQ1:    state_d = S_TQ2;
      S_TQ2:    state_d = S_DONE;
      S_TMUL:   state_d = S_TADD;
      S_TADD:   state_d = (k_q == 3'(NumProd - 1)) ? S_WRAP : S_TMUL;
      S_WRAP:   state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // body state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= InvMassRst[30:0];
      max_angle_q <= MaxAngleRst[30:0];
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0;
      ang_q <= '0; w_q <= '0; afx_q <= '0; afy_q <= '0; atq_q <= '0;
      k_q <= '0; ax_q <= 1'b0; bit_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INV_MASS:  inv_mass_q  <= cfg_data_i;
          default:       max_angle_q <= cfg_data_i;
        endcase
      end
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          k_q  <= '0;
          ax_q <= 1'b0;
        end
        S_ZERO: begin
          afx_q <= sat32(66'(afx_q) + 66'(fx_q));
          afy_q <= sat32(66'(afy_q) + 66'(fy_q));
        end
        S_ASTORE: k_q <= k_q + 3'd1;
        S_RCMB:   bit_q <= '0;
        S_RDIV:   bit_q <= bit_q + 6'd1;
        S_RACC: begin
          if (ax_q) afy_q <= sat32(66'(afy_q) + 66'(rad_v));
          else      afx_q <= sat32(66'(afx_q) + 66'(rad_v));
          ax_q <= 1'b1;
        end
        S_TQ2: atq_q <= sat32(66'(atq_q) + tq);
        S_TADD: begin
          case (k_q)
            3'd0: vx_q  <= sat32(tsum);
            3'd1: vy_q  <= sat32(tsum);
            3'd2: px_q  <= sat32(tsum);
            3'd3: py_q  <= sat32(tsum);
            3'd4: w_q   <= sat32(tsum);
            default: ang_q <= sat32(tsum);
          endcase
          k_q <= k_q + 3'd1;
        end
        S_WRAP: begin
          if (33'(ang_q) > $signed({2'b0, max_angle_q})) begin
            ang_q <= ang_q - $signed({1'b0, max_angle_q});
          end
          afx_q <= '0; afy_q <= '0; atq_q <= '0;
        end
        S_DONE: ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          lx_q <= in_i.loc_x;  ly_q <= in_i.loc_y;
          fx_q <= in_i.force_x; fy_q <= in_i.force_y;
          dt_q <= in_i.dt;
        end
      end
      S_LEVER: begin
        rx_q <= rx_n;
        ry_q <= ry_n;
      end
      S_ASTORE: p_q[k_q] <= prod_q[63:0];
      S_SUMS: begin
        r2_q   <= p_q[0] + p_q[1];
        dneg_q <= dot[65];
        dmag_q <= dot[65] ? 64'(-dot) : dot[63:0];
      end
      S_RP1: lo_q <= prod_q[63:0];
      S_RCMB: begin
        ovf_q <= num[95:64] >= r2_q;
        rem_q <= {32'b0, num[95:64]};
        nl_q  <= num[63:0];
      end
      S_RDIV: begin
        rem_q <= dv_ge ? 64'(dv_t - {1'b0, r2_q}) : dv_t[63:0];
        nl_q  <= {nl_q[62:0], dv_ge};
      end
      S_TQ1: cross_q <= 65'(p_q[4]) - 65'(p_q[5]);
      S_DONE: begin
        o_px_q <= px_q; o_py_q <= py_q; o_vx_q <= vx_q; o_vy_q <= vy_q;
        o_ang_q <= ang_q; o_w_q <= w_q;
      end
      default: ;
    endcase
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.pos_x   = o_px_q;
  assign out_o.pos_y   = o_py_q;
  assign out_o.vel_x   = o_vx_q;
  assign out_o.vel_y   = o_vy_q;
  assign out_o.angle   = o_ang_q;
  assign out_o.ang_vel = o_w_q;

endmodule

// ===== sim/tb_rigid_body_force_integrator_unit.sv =====
// Testbench for the rigid body force integrator: directed and random requests vs a body predictor.
module tb_rigid_body_force_integrator_unit;
  import rbfi_pkg::*;

  typedef struct packed {
    logic               op;
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic        [16:0] dt;
  } body_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] angle;
    logic signed [31:0] ang_vel;
  } body_state_t;

  localparam int unsigned Frac = 16;
  localparam logic signed [31:0] SMax = 32'sh7fffffff;
  localparam logic signed [31:0] SMin = 32'sh80000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [30:0] cfg_data;

  rbfi_in_if  req_if ();
  rbfi_out_if res_if ();

  rigid_body_force_integrator_unit i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (req_if),
    .out_o     (res_if)
  );

  // predicted body state and register copies
  logic signed [31:0] b_px, b_py, b_vx, b_vy, b_ang, b_av, b_fx, b_fy, b_tq;
  longint             b_inv_mass, b_max_angle;

  body_req_t   pending_reqs[$];
  body_state_t expected_states[$];
  int          n_errors, n_checked, n_apply, n_tick, n_cfg, n_accepted;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return SMax;
    if (v < -64'sd2147483648) return SMin;
    return v[31:0];
  endfunction

  function automatic longint fixmul(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p < 0) return -((-p) >> Frac);
    return p >> Frac;
  endfunction

  // sign/magnitude of a + b without losing the top bit
  function automatic void signed_sum(input longint a, input longint b,
                                     output logic [63:0] mag, output logic neg);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    neg = s < 0;
    mag = neg ? 64'(-s) : 64'(s);
  endfunction

  function automatic longint radial_part(input logic [63:0] dmag, input logic dneg,
                                         input longint c, input logic [63:0] r2);
    logic [127:0] p, q;
    logic [63:0]  cmag;
    logic         neg;
    cmag = (c < 0) ? 64'(-c) : 64'(c);
    p = {64'b0, dmag} * {64'b0, cmag};
    neg = dneg != (c < 0);
    if (p[127:64] >= r2) return neg ? longint'(SMin) : longint'(SMax);
    q = p / {64'b0, r2};
    if (neg) return (q >= 128'h8000_0000) ? longint'(SMin) : -longint'(q[63:0]);
    return (q > 128'h7fff_ffff) ? longint'(SMax) : longint'(q[63:0]);
  endfunction

  task automatic advance_body(input body_req_t r);
    longint       rx, ry;
    logic [63:0]  r2, dmag, cmag;
    logic         dneg, cneg;
    longint       tq;
    body_state_t  s;
    if (r.op == OP_APPLY) begin
      n_apply++;
      rx = clamp32(longint'(r.loc_x) - longint'(b_px));
      ry = clamp32(longint'(r.loc_y) - longint'(b_py));
      if (rx == 0 && ry == 0) begin
        b_fx = clamp32(longint'(b_fx) + longint'(r.force_x));
        b_fy = clamp32(longint'(b_fy) + longint'(r.force_y));
      end else begin
        r2 = 64'(rx * rx) + 64'(ry * ry);
        signed_sum(rx * longint'(r.force_x), ry * longint'(r.force_y), dmag, dneg);
        b_fx = clamp32(longint'(b_fx) + radial_part(dmag, dneg, rx, r2));
        b_fy = clamp32(longint'(b_fy) + radial_part(dmag, dneg, ry, r2));
        signed_sum(rx * longint'(r.force_y), -(ry * longint'(r.force_x)), cmag, cneg);
        cmag = cmag >> Frac;
        tq = cneg ? -longint'(cmag) : longint'(cmag);
        b_tq = clamp32(longint'(b_tq) + tq);
      end
    end else begin
      n_tick++;
      b_vx  = clamp32(longint'(b_vx) + fixmul(b_fx, b_inv_mass));
      b_vy  = clamp32(longint'(b_vy) + fixmul(b_fy, b_inv_mass));
      b_px  = clamp32(longint'(b_px) + fixmul(b_vx, longint'(r.dt)));
      b_py  = clamp32(longint'(b_py) + fixmul(b_vy, longint'(r.dt)));
      b_av  = clamp32(longint'(b_av) + fixmul(b_tq, b_inv_mass));
      b_ang = clamp32(longint'(b_ang) + fixmul(b_av, longint'(r.dt)));
      if (longint'(b_ang) > b_max_angle) b_ang = 32'(longint'(b_ang) - b_max_angle);
      b_fx = '0;
      b_fy = '0;
      b_tq = '0;
    end
    s = '{b_px, b_py, b_vx, b_vy, b_ang, b_av};
    expected_states.push_back(s);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_apply(input logic signed [31:0] lx, input logic signed [31:0] ly,
                             input logic signed [31:0] fx, input logic signed [31:0] fy);
    body_req_t r;
    r = '{OP_APPLY, lx, ly, fx, fy, 17'($urandom)};
    advance_body(r);
  endtask

  task automatic queue_tick(input logic [16:0] dt);
    body_req_t r;
    r = '{OP_TICK, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), dt};
    advance_body(r);
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] base, input int span);
    return clamp32(longint'(base) + longint'($signed($urandom_range(0, 2 * span))) - span);
  endfunction

  task automatic queue_random_request();
    int unsigned k;
    logic [16:0] dt;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      dt = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      queue_tick(dt);
    end else if (k < 35) begin
      queue_apply(b_px, b_py, 32'($urandom), 32'($urandom));
    end else if (k < 75) begin
      queue_apply(near(b_px, 1 << 20), near(b_py, 1 << 20),
                  32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
                  32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)));
    end else if (k < 95) begin
      queue_apply(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom));
    end else begin
      queue_apply($urandom_range(0, 1) ? SMax : SMin, $urandom_range(0, 1) ? SMax : SMin,
                  $urandom_range(0, 1) ? SMax : SMin, $urandom_range(0, 1) ? SMax : SMin);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %h expected %h", n_checked, field, got, want);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    n_cfg++;
    if (idx == CFG_INV_MASS) b_inv_mass = longint'(val);
    else b_max_angle = longint'(val);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // request driver: bursts of random length separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid   <= 1'b0;
      req_if.op      <= OP_APPLY;
      req_if.loc_x   <= '0;
      req_if.loc_y   <= '0;
      req_if.force_x <= '0;
      req_if.force_y <= '0;
      req_if.dt      <= '0;
      burst_left     <= 1;
      gap_left       <= 0;
    end else begin
      if (req_if.valid && req_if.ready) n_accepted++;
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          body_req_t r;
          r = pending_reqs.pop_front();
          req_if.valid   <= 1'b1;
          req_if.op      <= r.op;
          req_if.loc_x   <= r.loc_x;
          req_if.loc_y   <= r.loc_y;
          req_if.force_x <= r.force_x;
          req_if.force_y <= r.force_y;
          req_if.dt      <= r.dt;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; receiver alternates between stalling and steady stretches
  int  cyc, hold_left;
  bit  held_once;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      cyc          <= 0;
      hold_left    <= 0;
      held_once    <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (res_if.valid && res_if.ready) begin
        body_state_t got, want;
        got = '{res_if.pos_x, res_if.pos_y, res_if.vel_x, res_if.vel_y,
                res_if.angle, res_if.ang_vel};
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected", got.pos_x, '0);
        end else begin
          want = expected_states.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
          if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
          if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
          if (got.ang_vel !== want.ang_vel)
            report_mismatch("ang_vel", got.ang_vel, want.ang_vel);
        end
        n_checked++;
      end
      // one long hold-off while requests keep coming
      if (!held_once && n_checked == 500) begin
        held_once    <= 1'b1;
        hold_left    <= 600;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= (hold_left == 1);
      end else if ((cyc / 3000) % 2 == 1) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 3) != 0) || (cyc % 7 == 0);
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || req_if.valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [30:0] phase_inv[5];
    logic [30:0] phase_max[5];
    n_errors = 0; n_checked = 0; n_apply = 0; n_tick = 0; n_cfg = 0; n_accepted = 0;
    b_px = '0; b_py = '0; b_vx = '0; b_vy = '0; b_ang = '0; b_av = '0;
    b_fx = '0; b_fy = '0; b_tq = '0;
    b_inv_mass  = 65536;
    b_max_angle = 411775;
    cfg_we = 1'b0; cfg_idx = CFG_INV_MASS; cfg_data = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero lever, extreme levers and forces, torque, wrap, dt corners
    queue_apply(32'sd0, 32'sd0, SMax, SMin);
    queue_tick(17'd0);
    queue_apply(32'sd65536, 32'sd0, 32'sd0, 32'sd3000000);
    queue_apply(32'sd0, 32'sd65536, 32'sd200000, 32'sd5000);
    queue_tick(17'd65536);
    queue_apply(SMax, SMin, SMin, SMax);
    queue_apply(SMin, SMax, SMax, SMax);
    queue_apply(SMin, SMin, SMin, SMin);
    queue_apply(32'sd1, 32'sd0, SMax, 32'sd0);
    queue_tick(17'h1ffff);
    queue_apply(b_px, b_py, 32'sd65536, -32'sd65536);
    queue_apply(32'sd100, -32'sd100, -32'sd1, 32'sd1);
    queue_tick(17'd1);
    queue_apply(32'sd0, 32'sd1000000, 32'sd40000000, 32'sd0);
    queue_tick(17'd65536);
    queue_tick(17'd65536);
    queue_tick(17'd32768);
    queue_apply(32'hffffffff, 32'h0, 32'h7fff0000, 32'h80000001);

    phase_inv = '{31'd65536, 31'd0, 31'h7fffffff, 31'd4096, 31'($urandom)};
    phase_max = '{31'd411775, 31'd1, 31'h7fffffff, 31'd411775, 31'($urandom) | 31'd1};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_reg(CFG_INV_MASS, phase_inv[p]);
        write_reg(CFG_MAX_ANGLE, phase_max[p]);
      end
      for (int i = 0; i < 266; i++) queue_random_request();
    end
    drain();

    $display("Covered %0d apply-force and %0d tick requests (%0d accepted), %0d results checked,",
             n_apply, n_tick, n_accepted, n_checked);
    $display("over %0d register writes including zero and full-scale settings.", n_cfg);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rbfi_pkg.sv
rtl/core/rbfi_if.sv
rtl/core/rigid_body_force_integrator_unit.sv
sim/tb_rigid_body_force_integrator_unit.sv
